FILE: hdl/gcm_pkg.sv
package gcm_pkg;

  localparam int unsigned LabelW = 8;
  localparam int unsigned CutW = 13;
  localparam int unsigned CompW = 9;
  localparam int unsigned RankW = 4;
  localparam int unsigned EdgeW = 2 * LabelW;
  localparam logic [CompW-1:0] StopComponents = CompW'(2);
  localparam logic [RankW-1:0] RankTop = RankW'(15);
  localparam logic [CompW-1:0] VertexCountReset = CompW'(256);

  localparam logic KindLoad = 1'b0;
  localparam logic KindRun = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [LabelW-1:0] u_vertex;
    logic [LabelW-1:0] v_vertex;
  } gcm_in_t;

  typedef struct packed {
    logic [CutW-1:0]  cut_size;
    logic [CompW-1:0] components_left;
    logic             edges_dropped;
  } gcm_out_t;

  typedef struct packed {
    logic [CompW-1:0] vertex_count;
  } gcm_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gcm_stat_t;

endpackage

FILE: hdl/gcm_chan_if.sv
interface gcm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/gcm_ram.sv
module gcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hdl/gcm_ctrl.sv
module gcm_ctrl #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              ack_i,
  input  logic [gcm_pkg::CompW-1:0]         vertex_count_i,
  input  logic [$clog2(MAX_EDGES+1)-1:0]    edge_total_i,
  output logic [$clog2(MAX_EDGES)-1:0]      edge_raddr_o,
  input  logic [gcm_pkg::EdgeW-1:0]         edge_rdata_i,
  output logic                              par_we_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   par_waddr_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   par_wdata_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   par_raddr_o,
  input  logic [$clog2(MAX_VERTICES)-1:0]   par_rdata_i,
  output logic                              rank_we_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   rank_waddr_o,
  output logic [gcm_pkg::RankW-1:0]         rank_wdata_o,
  output logic [$clog2(MAX_VERTICES)-1:0]   rank_raddr_o,
  input  logic [gcm_pkg::RankW-1:0]         rank_rdata_i,
  output gcm_pkg::gcm_stat_t                stat_o,
  output logic [gcm_pkg::CutW-1:0]          cut_o,
  output logic [gcm_pkg::CompW-1:0]         comps_o
);
  import gcm_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned TW = $clog2(MAX_EDGES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_EDGE, S_ELAT, S_FIND, S_FCHK,
    S_CRD, S_CWR, S_RK1, S_RK2, S_RK3, S_DONE
  } state_e;

  state_e           state_q;
  logic [VW-1:0]    idx_q;
  logic [TW-1:0]    k_q;
  logic [TW-1:0]    cut_q;
  logic [CompW-1:0] comps_q;
  logic [VW-1:0]    cur_q, start_q, root_q, ra_q, rb_q, v_q;
  logic [RankW-1:0] rka_q;
  logic             side_q;
  logic             cut_phase_q;
  logic             a_wins;
  logic [VW-1:0]    u_lab, v_lab;

  assign u_lab = VW'(32'(edge_rdata_i[EdgeW-1:LabelW]) % MAX_VERTICES);
  assign v_lab = VW'(32'(edge_rdata_i[LabelW-1:0]) % MAX_VERTICES);
  assign a_wins = rka_q > rank_rdata_i;

  assign edge_raddr_o = k_q[EAW-1:0];
  assign par_raddr_o = (state_q == S_FCHK) ? par_rdata_i : cur_q;
  assign rank_raddr_o = (state_q == S_RK2) ? rb_q : ra_q;

  always_comb begin
    par_we_o = 1'b0;
    par_waddr_o = cur_q;
    par_wdata_o = root_q;
    rank_we_o = 1'b0;
    rank_waddr_o = rb_q;
    rank_wdata_o = rank_rdata_i + RankW'(1);
    unique case (state_q)
      S_CLR: begin
        par_we_o = 1'b1;
        par_waddr_o = idx_q;
        par_wdata_o = idx_q;
        rank_we_o = 1'b1;
        rank_waddr_o = idx_q;
        rank_wdata_o = '0;
      end
      S_CWR: begin
        par_we_o = 1'b1;
      end
      S_RK3: begin
        par_we_o = 1'b1;
        par_waddr_o = a_wins ? rb_q : ra_q;
        par_wdata_o = a_wins ? ra_q : rb_q;
        rank_we_o = (rka_q == rank_rdata_i) && (rank_rdata_i != RankTop);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      k_q <= '0;
      cut_q <= '0;
      comps_q <= '0;
      cur_q <= '0;
      start_q <= '0;
      root_q <= '0;
      ra_q <= '0;
      rb_q <= '0;
      v_q <= '0;
      rka_q <= '0;
      side_q <= 1'b0;
      cut_phase_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            idx_q <= '0;
            state_q <= S_CLR;
          end
        end
        S_CLR: begin
          idx_q <= idx_q + VW'(1);
          if (idx_q == VW'(MAX_VERTICES - 1)) begin
            comps_q <= vertex_count_i;
            k_q <= '0;
            cut_phase_q <= 1'b0;
            state_q <= S_EDGE;
          end
        end
        S_EDGE: begin
          if (!cut_phase_q) begin
            if ((k_q == edge_total_i) || (comps_q <= StopComponents)) begin
              cut_phase_q <= 1'b1;
              k_q <= '0;
              cut_q <= '0;
            end else begin
              state_q <= S_ELAT;
            end
          end else if (k_q == edge_total_i) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_ELAT;
          end
        end
        S_ELAT: begin
          cur_q <= u_lab;
          start_q <= u_lab;
          v_q <= v_lab;
          side_q <= 1'b0;
          state_q <= S_FIND;
        end
        S_FIND: begin
          state_q <= S_FCHK;
        end
        S_FCHK: begin
          if (par_rdata_i == cur_q) begin
            root_q <= cur_q;
            cur_q <= start_q;
            state_q <= S_CRD;
          end else begin
            cur_q <= par_rdata_i;
          end
        end
        S_CRD: begin
          if (cur_q != root_q) begin
            state_q <= S_CWR;
          end else if (!side_q) begin
            ra_q <= root_q;
            side_q <= 1'b1;
            cur_q <= v_q;
            start_q <= v_q;
            state_q <= S_FIND;
          end else if (!cut_phase_q && (ra_q != root_q)) begin
            rb_q <= root_q;
            state_q <= S_RK1;
          end else begin
            if (ra_q != root_q) begin
              cut_q <= cut_q + TW'(1);
            end
            k_q <= k_q + TW'(1);
            state_q <= S_EDGE;
          end
        end
        S_CWR: begin
          cur_q <= par_rdata_i;
          state_q <= S_CRD;
        end
        S_RK1: begin
          state_q <= S_RK2;
        end
        S_RK2: begin
          rka_q <= rank_rdata_i;
          state_q <= S_RK3;
        end
        S_RK3: begin
          comps_q <= comps_q - CompW'(1);
          k_q <= k_q + TW'(1);
          state_q <= S_EDGE;
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy = (state_q != S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign cut_o = CutW'(cut_q);
  assign comps_o = comps_q;
endmodule

FILE: hdl/graph_contraction_min_cut_top.sv
// Graph contraction for a min-cut estimate, one trial per run request.
// Input requests arrive on in_i. A load request (kind low) appends one edge
// to the edge store; edges past MAX_EDGES are dropped and
// a sticky flag is set. A run request (kind high) rebuilds the union-find,
// merges along the stored edges in order until two components remain or no
// edge is left, and then counts the edges that cross the partition. One
// result request per run leaves on out_o; loads give none.
// A run first reloads every entry of the parent and rank tables, up to
// MAX_VERTICES. Each stored edge is then read and latched; for each endpoint
// the parent chain is walked to the root, one hop a cycle on the parent-table
// read port, and then compressed with a read and a write per hop. Each merge
// then updates the ranks. The merge pass stops once two components remain
// or no edge is left, and the count pass walks every stored edge. in_i is
// not ready while a run is in progress.
// cfg_i is always ready; vertex_count should be written only while no run is
// in progress.
// Reset empties the edge store count, clears the drop flag, sets
// vertex_count to 256 and leaves no result pending. When the receiver stalls,
// the result waits in the output register; loads are still taken, and a
// further run finishes but holds its result until the register frees up.
module graph_contraction_min_cut_top #(
  parameter int unsigned MAX_VERTICES = 256,
  parameter int unsigned MAX_EDGES = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gcm_chan_if.sink   in_i,
  gcm_chan_if.sink   cfg_i,
  gcm_chan_if.source out_o
);
  import gcm_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned TW = $clog2(MAX_EDGES + 1);

  logic [TW-1:0]    edge_total_q;
  logic             overflow_q;
  logic [CompW-1:0] vertex_count_q;
  logic             out_valid_q;
  gcm_out_t         out_data_q;

  gcm_stat_t        stat;
  logic             in_take, load_take, run_take, room, ack;
  logic [EAW-1:0]   edge_raddr;
  logic [EdgeW-1:0] edge_rdata;
  logic             par_we, rank_we;
  logic [VW-1:0]    par_waddr, par_wdata, par_raddr, par_rdata;
  logic [VW-1:0]    rank_waddr, rank_raddr;
  logic [RankW-1:0] rank_wdata, rank_rdata;
  logic [CutW-1:0]  cut;
  logic [CompW-1:0] comps;

  assign in_i.ready = !stat.busy;
  assign cfg_i.ready = 1'b1;
  assign in_take = in_i.valid && in_i.ready;
  assign load_take = in_take && (in_i.data.kind == KindLoad);
  assign run_take = in_take && (in_i.data.kind == KindRun);
  assign room = edge_total_q < TW'(MAX_EDGES);

  // The result register takes a finished run once it is empty or draining.
  assign ack = stat.done && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      overflow_q <= 1'b0;
      vertex_count_q <= VertexCountReset;
      out_valid_q <= 1'b0;
    end else begin
      if (load_take) begin
        if (room) begin
          edge_total_q <= edge_total_q + TW'(1);
        end else begin
          overflow_q <= 1'b1;
        end
      end
      if (cfg_i.valid) begin
        vertex_count_q <= cfg_i.data.vertex_count;
      end
      out_valid_q <= ack || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_data_q.cut_size <= cut;
      out_data_q.components_left <= comps;
      out_data_q.edges_dropped <= overflow_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data = out_data_q;

  // Edge store: u label in the high byte, v label in the low byte.
  gcm_ram #(.Width(EdgeW), .Depth(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (load_take && room),
    .waddr_i (edge_total_q[EAW-1:0]),
    .wdata_i ({in_i.data.u_vertex, in_i.data.v_vertex}),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  gcm_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (par_waddr),
    .wdata_i (par_wdata),
    .raddr_i (par_raddr),
    .rdata_o (par_rdata)
  );

  gcm_ram #(.Width(RankW), .Depth(MAX_VERTICES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (rank_waddr),
    .wdata_i (rank_wdata),
    .raddr_i (rank_raddr),
    .rdata_o (rank_rdata)
  );

  gcm_ctrl #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (run_take),
    .ack_i          (ack),
    .vertex_count_i (vertex_count_q),
    .edge_total_i   (edge_total_q),
    .edge_raddr_o   (edge_raddr),
    .edge_rdata_i   (edge_rdata),
    .par_we_o       (par_we),
    .par_waddr_o    (par_waddr),
    .par_wdata_o    (par_wdata),
    .par_raddr_o    (par_raddr),
    .par_rdata_i    (par_rdata),
    .rank_we_o      (rank_we),
    .rank_waddr_o   (rank_waddr),
    .rank_wdata_o   (rank_wdata),
    .rank_raddr_o   (rank_raddr),
    .rank_rdata_i   (rank_rdata),
    .stat_o         (stat),
    .cut_o          (cut),
    .comps_o        (comps)
  );
endmodule
